>>> src/sli_pkg.sv
// Package for the sorted list block: widths, default depth and result status codes.
// Used by sli_cell and sorted_list_insert_remove; depends on nothing else.
`default_nettype none

package sli_pkg;

    localparam int DATA_W         = 32;
    localparam int LIST_DEPTH_DEF = 16;

    typedef logic signed [DATA_W-1:0] data_t;

    typedef enum logic [2:0] {
        ST_INSERTED = 3'd0,
        ST_REMOVED  = 3'd1,
        ST_ABSENT   = 3'd2,
        ST_EMPTY    = 3'd3,
        ST_FULL     = 3'd4
    } status_t;

    // Broadcast command to every cell of the row.
    typedef struct packed {
        logic  ins_en;
        logic  rem_en;
        data_t value;
    } cell_cmd_t;

endpackage

`default_nettype wire

>>> src/sorted_list_insert_remove.sv
// Top level of the sorted list: a row of sli_cell instances plus count and result logic.
// Depends on sli_pkg and sli_cell.
//
// Usage: a transaction is accepted at a rising edge where start is high and busy is
// low; action 0 inserts value in ascending order (after equal values), action 1
// removes the first stored copy of value. busy stays low, so a new transaction may
// be started in every cycle. The whole row of cells compares against the broadcast
// value and shifts in the accepting cycle, and the result appears in the cycle after
// acceptance: done is high for exactly one cycle with status, entry_count, smallest
// and largest describing the list after the operation. Throughput is one transaction
// per cycle, set by the compare-and-shift of the cell row. The receiver cannot stall;
// a result is shown once and is gone in the next cycle. smallest and largest read
// 0 when the list is empty. Reset (rst_n low, asynchronous) empties the list and
// clears done; stored values are not cleared, since only entries below the count
// are ever read.
`default_nettype none

module sorted_list_insert_remove #(
    parameter int LIST_DEPTH = sli_pkg::LIST_DEPTH_DEF,
    parameter int CNT_W      = $clog2(LIST_DEPTH + 1)
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire logic             action,
    input  wire sli_pkg::data_t   value,
    output logic                  done,
    output sli_pkg::status_t      status,
    output logic [CNT_W-1:0]      entry_count,
    output sli_pkg::data_t        smallest,
    output sli_pkg::data_t        largest
);
    import sli_pkg::*;

    data_t            cell_value [LIST_DEPTH];
    logic             cell_gt    [LIST_DEPTH];
    logic             cell_ge    [LIST_DEPTH];
    logic [LIST_DEPTH-1:0] cell_eq;

    cell_cmd_t        cmd;
    logic             accept;
    logic             full;
    logic             found;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    status_t          status_reg;
    status_t          status_next;
    logic             done_reg;
    data_t            last_value;

    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign full   = count_reg == CNT_W'(LIST_DEPTH);
    assign found  = |cell_eq;

    always_comb
    begin
        cmd.value   = value;
        cmd.ins_en  = accept && !action && !full;
        cmd.rem_en  = accept && action && found;
        count_next  = count_reg;
        status_next = status_reg;
        if (accept)
        begin
            if (!action)
            begin
                if (full)
                    status_next = ST_FULL;
                else
                begin
                    status_next = ST_INSERTED;
                    count_next  = count_reg + CNT_W'(1);
                end
            end
            else if (count_reg == '0)
                status_next = ST_EMPTY;
            else if (found)
            begin
                status_next = ST_REMOVED;
                count_next  = count_reg - CNT_W'(1);
            end
            else
                status_next = ST_ABSENT;
        end
    end

    for (genvar i = 0; i < LIST_DEPTH; i++)
    begin : g_cell
        data_t left_v;
        logic  left_g;
        data_t right_v;

        if (i == 0)
        begin : g_first
            assign left_v = value;
            assign left_g = 1'b0;
        end
        else
        begin : g_mid
            assign left_v = cell_value[i-1];
            assign left_g = cell_gt[i-1];
        end

        if (i == LIST_DEPTH - 1)
        begin : g_last
            assign right_v = cell_value[i];
        end
        else
        begin : g_inner
            assign right_v = cell_value[i+1];
        end

        sli_cell #(
            .IDX   (i),
            .CNT_W (CNT_W)
        ) u_cell (
            .clk         (clk),
            .cmd         (cmd),
            .count       (count_reg),
            .left_value  (left_v),
            .left_gt     (left_g),
            .right_value (right_v),
            .value       (cell_value[i]),
            .gt          (cell_gt[i]),
            .ge          (cell_ge[i]),
            .eq          (cell_eq[i])
        );
    end

    // Exactly one cell sits at the tail of a non-empty list, so an AND-OR picks it.
    always_comb
    begin
        last_value = '0;
        for (int i = 0; i < LIST_DEPTH; i++)
        begin
            if (count_reg == CNT_W'(i + 1))
                last_value = last_value | cell_value[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            status_reg <= ST_INSERTED;
            done_reg   <= 1'b0;
        end
        else
        begin
            count_reg  <= count_next;
            status_reg <= status_next;
            done_reg   <= accept;
        end
    end

    assign done        = done_reg;
    assign status      = status_reg;
    assign entry_count = count_reg;
    assign smallest    = (count_reg == '0) ? '0 : cell_value[0];
    assign largest     = last_value;

endmodule

`default_nettype wire

>>> src/sli_cell.sv
// One storage cell of the sorted row: holds a value, compares it with the broadcast
// value, and shifts in from its left or right neighbor. Depends on sli_pkg.
`default_nettype none

module sli_cell #(
    parameter int IDX   = 0,
    parameter int CNT_W = 5
) (
    input  wire logic              clk,
    input  wire sli_pkg::cell_cmd_t cmd,
    input  wire logic [CNT_W-1:0]  count,
    input  wire sli_pkg::data_t    left_value,
    input  wire logic              left_gt,
    input  wire sli_pkg::data_t    right_value,
    output sli_pkg::data_t         value,
    output logic                   gt,
    output logic                   ge,
    output logic                   eq
);
    import sli_pkg::*;

    data_t value_reg;
    data_t value_next;
    logic  occupied;
    logic  at_end;

    assign occupied = CNT_W'(IDX) < count;
    assign at_end   = CNT_W'(IDX) == count;
    assign gt       = occupied && (value_reg > cmd.value);
    assign ge       = occupied && (value_reg >= cmd.value);
    assign eq       = occupied && (value_reg == cmd.value);
    assign value    = value_reg;

    // The row stays sorted, so the greater flags rise once along it: on insert, a
    // cell with a greater left neighbor moves right, the first greater (or free)
    // cell takes the new value; on remove, cells >= the value shift left.
    always_comb
    begin
        value_next = value_reg;
        if (cmd.ins_en)
        begin
            if (left_gt)
                value_next = left_value;
            else if (gt || at_end)
                value_next = cmd.value;
        end
        else if (cmd.rem_en)
        begin
            if (ge)
                value_next = right_value;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

endmodule

`default_nettype wire

>>> tb/sli_checker.sv
// Checker for the sorted list block: watches the command and result channels,
// keeps its own copy of the list and compares every result field by field.
// Depends on sli_pkg for the data and status types.
`timescale 1ns / 1ps

module sli_checker #(
    parameter int DEPTH = sli_pkg::LIST_DEPTH_DEF,
    parameter int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic             busy,
    input  logic             action,
    input  sli_pkg::data_t   value,
    input  logic             done,
    input  sli_pkg::status_t status,
    input  logic [CNT_W-1:0] entry_count,
    input  sli_pkg::data_t   smallest,
    input  sli_pkg::data_t   largest,
    output int               mismatches,
    output int               pending,
    output int               checked,
    output int               full_hits,
    output int               empty_hits,
    output int               absent_hits
);
    import sli_pkg::*;

    typedef struct {
        status_t          st;
        logic [CNT_W-1:0] cnt;
        data_t            lo;
        data_t            hi;
    } list_view_t;

    list_view_t view_q[$];
    data_t      stored_vals[DEPTH];
    int         stored_len;
    int         err_n;
    int         checked_n;
    int         full_n;
    int         empty_n;
    int         absent_n;

    // Applies one insert or remove to the local list and returns the view after it.
    function automatic list_view_t apply_list_op(input logic act, input data_t v);
        list_view_t r;
        int         pos;
        int         hit;
        if (act == 1'b0)
        begin
            if (stored_len >= DEPTH)
            begin
                r.st = ST_FULL;
            end
            else
            begin
                // Goes in front of the first strictly greater value, behind any equal ones.
                pos = stored_len;
                for (int k = stored_len - 1; k >= 0; k--)
                    if (stored_vals[k] > v)
                        pos = k;
                for (int k = stored_len; k > pos; k--)
                    stored_vals[k] = stored_vals[k-1];
                stored_vals[pos] = v;
                stored_len++;
                r.st = ST_INSERTED;
            end
        end
        else if (stored_len == 0)
        begin
            r.st = ST_EMPTY;
        end
        else
        begin
            hit = -1;
            for (int k = stored_len - 1; k >= 0; k--)
                if (stored_vals[k] == v)
                    hit = k;
            if (hit < 0)
            begin
                r.st = ST_ABSENT;
            end
            else
            begin
                for (int k = hit; k < stored_len - 1; k++)
                    stored_vals[k] = stored_vals[k+1];
                stored_len--;
                r.st = ST_REMOVED;
            end
        end
        r.cnt = CNT_W'(stored_len);
        r.lo  = (stored_len > 0) ? stored_vals[0] : '0;
        r.hi  = (stored_len > 0) ? stored_vals[stored_len-1] : '0;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        list_view_t exp_view;
        if (!rst_n)
        begin
            stored_len = 0;
            view_q.delete();
            err_n     = 0;
            checked_n = 0;
            full_n    = 0;
            empty_n   = 0;
            absent_n  = 0;
        end
        else
        begin
            // The result of a transaction leaves in the cycle after it is accepted, so the
            // compare comes before the push of this edge's transaction.
            if (done)
            begin
                if (view_q.size() == 0)
                begin
                    err_n++;
                    if (err_n <= 10)
                        $display("%0t: result with nothing outstanding: status %0d count %0d",
                                 $realtime, status, entry_count);
                end
                else
                begin
                    exp_view = view_q.pop_front();
                    checked_n++;
                    if (exp_view.st == ST_FULL)
                        full_n++;
                    if (exp_view.st == ST_EMPTY)
                        empty_n++;
                    if (exp_view.st == ST_ABSENT)
                        absent_n++;
                    if (status !== exp_view.st || entry_count !== exp_view.cnt ||
                        smallest !== exp_view.lo || largest !== exp_view.hi)
                    begin
                        err_n++;
                        if (err_n <= 10)
                        begin
                            $display("%0t: mismatch, expected status %0d count %0d min %0d max %0d",
                                     $realtime, exp_view.st, exp_view.cnt, exp_view.lo,
                                     exp_view.hi);
                            $display("%0t:           actual status %0d count %0d min %0d max %0d",
                                     $realtime, status, entry_count, smallest, largest);
                        end
                    end
                end
            end
            if (start && !busy)
                view_q.push_back(apply_list_op(action, value));
        end
        mismatches  <= err_n;
        pending     <= view_q.size();
        checked     <= checked_n;
        full_hits   <= full_n;
        empty_hits  <= empty_n;
        absent_hits <= absent_n;
    end

endmodule

>>> tb/tb_top.sv
// Top of the sorted list testbench: clock, reset, directed and random command
// stimulus, and the verdict. Depends on sli_pkg, sorted_list_insert_remove and sli_checker.
`timescale 1ns / 1ps

module tb_top;
    import sli_pkg::*;

    localparam int CNT_W      = $clog2(LIST_DEPTH_DEF + 1);
    localparam int RAND_OPS   = 1300;
    localparam int QUIET_TAIL = 200;
    localparam int MAX_CYCLES = 200000;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    logic             clk;
    logic             rst_n;
    logic             start;
    logic             busy;
    logic             action;
    data_t            value;
    logic             done;
    status_t          status;
    logic [CNT_W-1:0] entry_count;
    data_t            smallest;
    data_t            largest;

    int mismatches;
    int pending;
    int checked;
    int full_hits;
    int empty_hits;
    int absent_hits;
    int cycle_cnt;
    int insert_ops;
    int remove_ops;
    bit gaps_on;

    data_t corner_vals[11] = '{
        data_t'(32'h8000_0000), data_t'(32'h8000_0001), -1000, -7, -1, 0, 1, 7, 1000,
        data_t'(32'h7FFF_FFFE), data_t'(32'h7FFF_FFFF)
    };

    sorted_list_insert_remove DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .action      (action),
        .value       (value),
        .done        (done),
        .status      (status),
        .entry_count (entry_count),
        .smallest    (smallest),
        .largest     (largest)
    );

    sli_checker #(.DEPTH(LIST_DEPTH_DEF)) u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .action      (action),
        .value       (value),
        .done        (done),
        .status      (status),
        .entry_count (entry_count),
        .smallest    (smallest),
        .largest     (largest),
        .mismatches  (mismatches),
        .pending     (pending),
        .checked     (checked),
        .full_hits   (full_hits),
        .empty_hits  (empty_hits),
        .absent_hits (absent_hits)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Corner values and a narrow band around zero give plenty of duplicates and
    // remove hits; full-width draws exercise every bit of the value.
    function automatic data_t pick_value();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 4)
            return corner_vals[$urandom_range(0, 10)];
        else if (sel < 7)
            return data_t'($urandom_range(0, 40)) - 20;
        else
            return data_t'($urandom);
    endfunction

    task automatic issue_op(input logic act, input data_t val);
        if (gaps_on && $urandom_range(0, 2) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        start  <= 1'b1;
        action <= act;
        value  <= val;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        if (act == OP_INSERT)
            insert_ops++;
        else
            remove_ops++;
    endtask

    initial
    begin
        int ins_pct;
        rst_n      = 1'b0;
        start      = 1'b0;
        action     = OP_INSERT;
        value      = '0;
        gaps_on    = 1'b0;
        insert_ops = 0;
        remove_ops = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty list, single entry, extremes, duplicates, absent value, full list.
        gaps_on = 1'b1;
        issue_op(OP_REMOVE, 5);
        issue_op(OP_INSERT, 5);
        issue_op(OP_REMOVE, 5);
        issue_op(OP_INSERT, data_t'(32'h8000_0000));
        issue_op(OP_INSERT, data_t'(32'h7FFF_FFFF));
        issue_op(OP_INSERT, 0);
        issue_op(OP_INSERT, 0);
        issue_op(OP_REMOVE, 0);
        issue_op(OP_REMOVE, 9);
        issue_op(OP_REMOVE, data_t'(32'h8000_0000));
        issue_op(OP_INSERT, -1);
        for (int k = 0; k < LIST_DEPTH_DEF - 3; k++)
            issue_op(OP_INSERT, pick_value());
        issue_op(OP_INSERT, 3);
        issue_op(OP_REMOVE, data_t'(32'h7FFF_FFFF));

        // Random: phases that lean toward filling or draining swing the list
        // between empty and full.
        ins_pct = 50;
        for (int i = 0; i < RAND_OPS; i++)
        begin
            if (i % 40 == 0)
                ins_pct = ($urandom_range(0, 2) == 0) ? 50 : ($urandom_range(0, 1) ? 80 : 20);
            if (i % 50 == 0)
                gaps_on = ($urandom_range(0, 2) != 0);
            if (i >= RAND_OPS - QUIET_TAIL)
                gaps_on = 1'b0;
            issue_op(($urandom_range(0, 99) < ins_pct) ? OP_INSERT : OP_REMOVE, pick_value());
        end
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (5) @(posedge clk);

        $display("Ran %0d inserts and %0d removes; %0d results checked.",
                 insert_ops, remove_ops, checked);
        $display("Refused on full list: %0d, remove on empty list: %0d, absent value: %0d.",
                 full_hits, empty_hits, absent_hits);
        if (mismatches == 0)
            $display("sorted_list_insert_remove regression: pass");
        else
            $display("sorted_list_insert_remove regression: fail");
        $finish;
    end

    initial
    begin
        cycle_cnt = 0;
        while (cycle_cnt < MAX_CYCLES)
        begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("Timed out after %0d cycles with %0d results outstanding.", cycle_cnt, pending);
        $display("sorted_list_insert_remove regression: fail");
        $finish;
    end

endmodule
